/* rtl/core/sdx_pkg.sv */
// Package holding the transaction types, the letter table and the shared constants.
package sdx_pkg;

  localparam int unsigned CODE_DIGITS = 3;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned DIGIT_W     = 3;
  localparam int unsigned COUNT_W     = 2;

  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] lead_letter;
    digit_t            digit_one;
    digit_t            digit_two;
    digit_t            digit_three;
  } out_item_t;

  // Code digit for each letter A..Z, indexed from A; 0 means the letter is dropped.
  function automatic digit_t letter_code(input logic [4:0] idx);
    digit_t code;
    unique case (idx)
      5'd1, 5'd5, 5'd15, 5'd21:                        code = 3'd1;
      5'd2, 5'd6, 5'd9, 5'd10, 5'd16, 5'd18, 5'd23, 5'd25: code = 3'd2;
      5'd3, 5'd19:                                     code = 3'd3;
      5'd11:                                           code = 3'd4;
      5'd12, 5'd13:                                    code = 3'd5;
      5'd17:                                           code = 3'd6;
      default:                                         code = 3'd0;
    endcase
    return code;
  endfunction

endpackage

/* rtl/core/sdx_in_reg.sv */
// Input register stage holding one accepted character transaction.
module sdx_in_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  sdx_pkg::in_item_t in_item,
  input  logic             advance,
  output logic             held_valid,
  output sdx_pkg::in_item_t held_item
);

  logic              valid_r;
  logic              valid_nxt;
  sdx_pkg::in_item_t item_r;

  // The stage takes a new transaction whenever it is empty or being emptied.
  assign in_ready = !valid_r || advance;
  assign valid_nxt = in_valid ? 1'b1 : (valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign held_valid = valid_r;
  assign held_item  = item_r;

endmodule

/* rtl/core/sdx_coder.sv */
// Word state and the per-character coding logic.
module sdx_coder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  sdx_pkg::in_item_t  item,
  output sdx_pkg::out_item_t result
);

  logic                          started_r;
  logic [sdx_pkg::CHAR_W-1:0]    lead_r;
  sdx_pkg::count_t               count_r;
  sdx_pkg::digit_t               store_r [sdx_pkg::CODE_DIGITS];

  logic                          started_nxt;
  logic [sdx_pkg::CHAR_W-1:0]    lead_nxt;
  sdx_pkg::count_t               count_nxt;
  sdx_pkg::digit_t               store_nxt [sdx_pkg::CODE_DIGITS];

  logic [sdx_pkg::CHAR_W-1:0]    up;
  logic                          is_lower;
  logic                          is_letter;
  logic [sdx_pkg::CHAR_W-1:0]    letter_off;
  sdx_pkg::digit_t               code;
  sdx_pkg::digit_t               prev_digit;
  logic                          take;

  assign is_lower   = (item.char_code >= sdx_pkg::CHAR_LOWER_A) &&
                      (item.char_code <= sdx_pkg::CHAR_LOWER_Z);
  assign up         = is_lower ? (item.char_code - sdx_pkg::CASE_OFFSET) : item.char_code;
  assign is_letter  = (up >= sdx_pkg::CHAR_UPPER_A) && (up <= sdx_pkg::CHAR_UPPER_Z);
  assign letter_off = up - sdx_pkg::CHAR_UPPER_A;
  assign code       = sdx_pkg::letter_code(letter_off[4:0]);

  always_comb begin
    unique case (count_r)
      2'd1:    prev_digit = store_r[0];
      2'd2:    prev_digit = store_r[1];
      2'd3:    prev_digit = store_r[2];
      default: prev_digit = '0;
    endcase
  end

  // A repeat of the lead letter is skipped only while no digit is stored.
  assign take = started_r && (count_r != sdx_pkg::count_t'(sdx_pkg::CODE_DIGITS)) &&
                is_letter && (code != '0) &&
                !((count_r != '0) && (prev_digit == code)) &&
                !((count_r == '0) && (up == lead_r));

  always_comb begin
    started_nxt = 1'b1;
    lead_nxt    = started_r ? lead_r : up;
    count_nxt   = take ? (count_r + 2'd1) : count_r;
    for (int i = 0; i < sdx_pkg::CODE_DIGITS; i++) begin
      store_nxt[i] = (take && (count_r == sdx_pkg::count_t'(i))) ? code : store_r[i];
    end
  end

  assign result.lead_letter = lead_nxt;
  assign result.digit_one   = store_nxt[0];
  assign result.digit_two   = store_nxt[1];
  assign result.digit_three = store_nxt[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      lead_r    <= '0;
      count_r   <= '0;
      for (int i = 0; i < sdx_pkg::CODE_DIGITS; i++) begin
        store_r[i] <= '0;
      end
    end else if (step) begin
      if (item.last_char) begin
        started_r <= 1'b0;
        lead_r    <= '0;
        count_r   <= '0;
        for (int i = 0; i < sdx_pkg::CODE_DIGITS; i++) begin
          store_r[i] <= '0;
        end
      end else begin
        started_r <= started_nxt;
        lead_r    <= lead_nxt;
        count_r   <= count_nxt;
        for (int i = 0; i < sdx_pkg::CODE_DIGITS; i++) begin
          store_r[i] <= store_nxt[i];
        end
      end
    end
  end

endmodule

/* rtl/core/sdx_out_reg.sv */
// Result register holding one finished code until it is taken.
module sdx_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  sdx_pkg::out_item_t load_item,
  output logic               free,
  output logic               out_valid,
  input  logic               out_ready,
  output sdx_pkg::out_item_t out_item
);

  logic               valid_r;
  logic               valid_nxt;
  sdx_pkg::out_item_t item_r;

  assign free      = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= load_item;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

/* rtl/core/soundex_encoder.sv */
// Top level of the streaming Soundex coder.
//
// The block takes a word one character per transaction, first character
// first, with last_char set on the final one. The first character is kept,
// folded to upper case, as the lead letter; later letters are folded, mapped
// to code digits 1 to 6, with vowels, H, W and Y dropped, a repeat of the
// last stored digit dropped, and, before any digit is stored, a repeat of
// the lead letter skipped. Non-letters after the first character are
// ignored. At most three digits are kept and unused digits read 0. One
// result transaction appears for each character flagged last, after which a
// new word starts. Each character passes from the input register through
// the table lookup and a few compares into the word state, and a final
// character also loads the result register, so the result is offered in
// the cycle after the final character has left the input register and can
// be taken at the edge that follows. A character is accepted in every cycle
// while results are being taken; a final character only waits when the
// previous result is still held in the result register.
module soundex_encoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sdx_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output sdx_pkg::out_item_t out_item
);

  logic               held_valid;
  sdx_pkg::in_item_t  held_item;
  logic               out_free;
  logic               advance;
  logic               load_result;
  sdx_pkg::out_item_t result;

  // A held character moves on unless it ends a word and the result register
  // is still occupied by an earlier code that has not been taken.
  assign advance     = held_valid && (!held_item.last_char || out_free);
  assign load_result = advance && held_item.last_char;

  sdx_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  sdx_coder u_coder (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (held_item),
    .result (result)
  );

  sdx_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load_result),
    .load_item (result),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

/* tb/tb_soundex_encoder.sv */
// Self-checking testbench for the streaming Soundex coder, with its own predictor of the codes.
module tb_soundex_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  // Number of random characters to feed after the directed words.
  localparam int RANDOM_CHARS  = 1750;
  // The slowest correct run is roughly 1750 characters, each waiting out a
  // sender gap drawn by pick_gap, about 300 results that each wait out a
  // receiver stall, and a few pauses for the result queue to drain; the
  // limit leaves a wide margin.
  localparam int CYCLE_LIMIT   = 200_000;
  // A result is offered once its final character has moved through the input
  // register into the result register, so a handful of quiet cycles at the end is enough to expose a stray one.
  localparam int SETTLE_CYCLES = 8;

  // A character waiting to be driven. The hold flag makes the sender wait
  // until every expected code has been received before presenting it.
  typedef struct packed {
    logic              hold;
    sdx_pkg::in_item_t item;
  } feed_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  sdx_pkg::in_item_t  in_item   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  sdx_pkg::out_item_t out_item;

  feed_t              char_feed [$];
  sdx_pkg::out_item_t code_queue [$];

  // Handshake flags, set at each rising edge and read at the next falling one.
  bit         in_took  = 1'b0;
  bit         out_took = 1'b0;

  // Idling control. A calm side does not idle at all, which gives stretches
  // of back-to-back transactions between the noisy ones.
  int         send_gap   = 0;
  int         take_stall = 0;
  bit         send_calm  = 1'b0;
  bit         take_calm  = 1'b0;

  int         fault_count = 0;
  int         cycle_count = 0;

  // Predictor state for the word being built.
  bit              word_open;
  logic [7:0]      lead_char;
  int              digit_cnt;
  sdx_pkg::digit_t digit_mem [sdx_pkg::CODE_DIGITS];

  soundex_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Reset is held low from the start and released on a falling edge, so that
  // the block sees it change well away from the edge at which it samples.
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Only a..z are folded; every other code is passed through unchanged.
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= sdx_pkg::CHAR_LOWER_A && c <= sdx_pkg::CHAR_LOWER_Z) begin
      return c - sdx_pkg::CASE_OFFSET;
    end
    return c;
  endfunction

  // Sound group of an upper-case letter. Vowels, H, W and Y carry no digit.
  function automatic sdx_pkg::digit_t sound_digit(input logic [7:0] up);
    case (up)
      "B", "F", "P", "V":                     return 3'd1;
      "C", "G", "J", "K", "Q", "S", "X", "Z": return 3'd2;
      "D", "T":                               return 3'd3;
      "L":                                    return 3'd4;
      "M", "N":                               return 3'd5;
      "R":                                    return 3'd6;
      default:                                return 3'd0;
    endcase
  endfunction

  function automatic void clear_word();
    word_open = 1'b0;
    lead_char = '0;
    digit_cnt = 0;
    for (int i = 0; i < sdx_pkg::CODE_DIGITS; i++) begin
      digit_mem[i] = '0;
    end
  endfunction

  // Advances the word state by one accepted character. Returns 1 when the
  // character closes the word, with the expected code in code.
  function automatic bit encode_char(input sdx_pkg::in_item_t ch,
                                     output sdx_pkg::out_item_t code);
    logic [7:0]      up;
    sdx_pkg::digit_t d;
    bit              keep;
    up = fold_case(ch.char_code);
    if (!word_open) begin
      lead_char = up;
      word_open = 1'b1;
    end else if (digit_cnt < sdx_pkg::CODE_DIGITS && up >= sdx_pkg::CHAR_UPPER_A &&
                 up <= sdx_pkg::CHAR_UPPER_Z) begin
      d    = sound_digit(up);
      keep = (d != 3'd0);
      // A letter sounding like the last stored digit adds nothing, even when
      // vowels or H, W, Y stand between them.
      if (keep && digit_cnt > 0) begin
        if (digit_mem[digit_cnt-1] == d) keep = 1'b0;
      end
      // Before the first digit, a repeat of the lead letter is skipped.
      if (keep && digit_cnt == 0 && up == lead_char) keep = 1'b0;
      if (keep) begin
        digit_mem[digit_cnt] = d;
        digit_cnt++;
      end
    end
    code.lead_letter = lead_char;
    code.digit_one   = digit_mem[0];
    code.digit_two   = digit_mem[1];
    code.digit_three = digit_mem[2];
    if (ch.last_char) clear_word();
    return ch.last_char;
  endfunction

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  task automatic note_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fault_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      note_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  // Monitor: every handshake is seen at the rising edge on the values that
  // stood before it. Results are compared before the predictor runs, since a
  // code can never leave the block in the same cycle as its final character
  // is taken, and the queue order must not depend on that.
  always @(posedge clk) begin : watch_ports
    sdx_pkg::out_item_t want;
    in_took  = 1'b0;
    out_took = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        out_took = 1'b1;
        if (code_queue.size() == 0) begin
          note_mismatch($sformatf("code %h arrived with no word pending", out_item));
        end else begin
          want = code_queue.pop_front();
          check_field("lead_letter", int'(out_item.lead_letter), int'(want.lead_letter));
          check_field("digit_one",   int'(out_item.digit_one),   int'(want.digit_one));
          check_field("digit_two",   int'(out_item.digit_two),   int'(want.digit_two));
          check_field("digit_three", int'(out_item.digit_three), int'(want.digit_three));
        end
      end
      if (in_valid && in_ready) begin
        in_took = 1'b1;
        if (encode_char(in_item, want)) code_queue.push_back(want);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------

  function automatic int pick_gap(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 7));
  endfunction

  // Sender: a character stays on the bus until it is taken. After each one
  // a fresh gap is drawn, and a held character waits for the queue of
  // expected codes to empty before it is shown.
  always @(negedge clk) begin : feed_chars
    bit    show;
    feed_t head;
    show = in_valid && !in_took;
    if (rst_n && !show) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (char_feed.size() > 0) begin
        head = char_feed[0];
        if (!(head.hold && code_queue.size() > 0)) begin
          in_item <= head.item;
          void'(char_feed.pop_front());
          show = 1'b1;
          if ($urandom_range(0, 47) == 0) send_calm = !send_calm;
          send_gap = pick_gap(send_calm);
        end
      end
    end
    in_valid <= show;
  end

  // Receiver: after each code taken it stalls for a freshly drawn number of
  // cycles, then stays ready until the next code comes.
  always @(negedge clk) begin : take_codes
    bit rdy;
    rdy = 1'b0;
    if (rst_n) begin
      if (out_took) begin
        if ($urandom_range(0, 47) == 0) take_calm = !take_calm;
        take_stall = pick_gap(take_calm);
      end
      if (take_stall > 0) begin
        take_stall--;
      end else begin
        rdy = 1'b1;
      end
    end
    out_ready <= rdy;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** soundex_encoder: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  task automatic queue_char(input logic [7:0] c, input bit last, input bit hold);
    feed_t f;
    f.hold           = hold;
    f.item.char_code = c;
    f.item.last_char = last;
    char_feed.push_back(f);
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      queue_char(s[i], i == s.len() - 1, 1'b0);
    end
  endtask

  // Gives a letter a random case; any other code is returned as it is.
  function automatic logic [7:0] mix_case(input logic [7:0] c);
    logic [7:0] up;
    up = fold_case(c);
    if (up >= sdx_pkg::CHAR_UPPER_A && up <= sdx_pkg::CHAR_UPPER_Z) begin
      return $urandom_range(0, 1) ? up : up + sdx_pkg::CASE_OFFSET;
    end
    return c;
  endfunction

  initial begin : stimulus
    int         fed;
    int         len;
    bit         hold;
    logic [7:0] c;
    logic [7:0] first;
    logic [7:0] prev;

    clear_word();

    // Directed words. Code zero and the top code as one-character words,
    // then a lower-case one-character word that must be folded.
    queue_char(8'h00, 1'b1, 1'b0);
    queue_char(8'hFF, 1'b1, 1'b0);
    queue_text("z");
    // The lead letter repeated in the other case is skipped before a digit.
    queue_text("Ppb");
    // Y dropped, a repeated digit dropped, and a K after a vowel that still
    // repeats the last digit.
    queue_text("Tymczak");
    // A non-letter lead, non-letters in the middle including the top half of
    // the code range, and letters after the third digit ignored.
    queue_char("@", 1'b0, 1'b0);
    queue_char("b", 1'b0, 1'b0);
    queue_char(8'h80, 1'b0, 1'b0);
    queue_char("{", 1'b0, 1'b0);
    queue_char("d", 1'b0, 1'b0);
    queue_char("L", 1'b0, 1'b0);
    queue_char("m", 1'b0, 1'b0);
    queue_char("r", 1'b1, 1'b0);

    // Random words, mostly short, with repeats of the previous character and
    // of the lead letter mixed in to reach the skipping rules often, and raw
    // codes of any value for noise.
    fed = 0;
    for (int w = 0; fed < RANDOM_CHARS; w++) begin
      len  = ($urandom_range(0, 15) == 0) ? int'($urandom_range(9, 20))
                                          : int'($urandom_range(1, 8));
      hold = (w == 0) || ($urandom_range(0, 39) == 0);
      first = '0;
      prev  = '0;
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 9))
          0:       c = 8'($urandom_range(0, 255));
          1:       c = mix_case(prev);
          2:       c = mix_case(first);
          default: c = 8'(($urandom_range(0, 1) ? sdx_pkg::CHAR_UPPER_A : sdx_pkg::CHAR_LOWER_A)
                          + $urandom_range(0, 25));
        endcase
        if (i == 0) first = c;
        prev = c;
        queue_char(c, i == len - 1, hold && i == 0);
        fed++;
      end
    end

    // Wait for every character to be taken, then for every code to come,
    // then a few quiet cycles to catch anything extra.
    @(posedge rst_n);
    while (char_feed.size() != 0 || in_valid) @(posedge clk);
    while (code_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (code_queue.size() != 0) begin
      note_mismatch($sformatf("%0d codes never arrived", code_queue.size()));
    end
    if (fault_count == 0) begin
      $display("** soundex_encoder: PASSED **");
    end else begin
      $display("** soundex_encoder: FAILED **");
    end
    $finish;
  end

endmodule
